>>> hw/rtl/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and codes for the front/middle/back queue: request action
// codes, cell move codes and the per-cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package fmbq_pkg;

  // Width of the reported item count field.
  localparam int COUNT_OUT_W = 5;

  // Request action codes.
  typedef enum logic [2:0] {
    ACT_INS_FRONT  = 3'd0,
    ACT_INS_MID    = 3'd1,
    ACT_INS_BACK   = 3'd2,
    ACT_TAKE_FRONT = 3'd3,
    ACT_TAKE_MID   = 3'd4,
    ACT_TAKE_BACK  = 3'd5
  } action_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    MOVE_HOLD  = 2'd0,  // keep own word
    MOVE_LOAD  = 2'd1,  // take the pushed word
    MOVE_LEFT  = 2'd2,  // take the word of the cell in front
    MOVE_RIGHT = 2'd3   // take the word of the cell behind
  } move_t;

  typedef struct packed {
    move_t move;
    logic  sel;   // this cell sits at the request position (read on a pop)
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fmbq_cell.sv
// ----------------------------------------------------------------------------
// fmbq_cell
// One storage cell of the queue chain: holds a word, shifts toward either
// neighbor or loads the pushed word, and drives its word onto the read OR-bus
// when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire fmbq_pkg::cell_ctl_t   ctl,
  input  wire logic [DATA_WIDTH-1:0] left_word,
  input  wire logic [DATA_WIDTH-1:0] right_word,
  input  wire logic [DATA_WIDTH-1:0] new_word,
  output logic      [DATA_WIDTH-1:0] word,
  output logic      [DATA_WIDTH-1:0] read_word
);

  always_ff @(posedge clk) begin
    case (ctl.move)
      fmbq_pkg::MOVE_LOAD:  word <= new_word;
      fmbq_pkg::MOVE_LEFT:  word <= left_word;
      fmbq_pkg::MOVE_RIGHT: word <= right_word;
      default:              word <= word;
    endcase
  end

  // masked so the top level can OR all cells together
  assign read_word = ctl.sel ? word : '0;

endmodule

`default_nettype wire

>>> hw/rtl/front_middle_back_queue.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue
// Bounded ordered queue of signed words with push and pop at the front, the
// middle or the back, built as a chain of word cells that all shift at once.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  request   req_valid / req_stall  action, value
//  result    res_valid / res_stall  result_value, empty_error, full_error, item_count
//
// Cycles: one request per cycle while not stalled. The whole cell chain shifts
//   in the cycle the request is taken; its result appears in the output register
//   at the next edge.
// Reset clears the item count and the result valid flag; cell words are not
//   reset and only cells below the count are ever read.
// Stalls: a request is stalled only while a result is waiting and res_stall
//   is high; the output register then holds its result unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module front_middle_back_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [2:0]                   action,
  input  wire logic signed [DATA_WIDTH-1:0] value,
  // result channel
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic signed [DATA_WIDTH-1:0]      result_value,
  output logic                              empty_error,
  output logic                              full_error,
  output logic [fmbq_pkg::COUNT_OUT_W-1:0]  item_count
);

  // count must hold DEPTH itself
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] pos;          // index the request works on
  logic          req_acc;
  logic          is_push;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic          do_ins;
  logic          do_rem;

  fmbq_pkg::cell_ctl_t           ctl   [DEPTH];
  logic [DATA_WIDTH-1:0]         words [DEPTH];
  logic [DATA_WIDTH-1:0]         reads [DEPTH];
  logic [DATA_WIDTH-1:0]         rd_word;
  logic [DATA_WIDTH-1:0]         res_word;
  logic [DEPTH-1:0]              sel_vec;

  // A new request may enter whenever the output register is free or drains
  // this cycle.
  assign req_stall = res_valid && res_stall;
  assign req_acc   = req_valid && !req_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Decode action and work position. Middle push goes to floor(n/2), middle
  // pop takes floor((n-1)/2). On an empty pop, count-1 wraps and may land on
  // a stale cell; the pop is masked anyway.
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos     = '0;
    case (action)
      fmbq_pkg::ACT_INS_FRONT: begin
        is_push = 1'b1;
        pos     = '0;
      end
      fmbq_pkg::ACT_INS_MID: begin
        is_push = 1'b1;
        pos     = count >> 1;
      end
      fmbq_pkg::ACT_INS_BACK: begin
        is_push = 1'b1;
        pos     = count;
      end
      fmbq_pkg::ACT_TAKE_FRONT: begin
        is_pop = 1'b1;
        pos    = '0;
      end
      fmbq_pkg::ACT_TAKE_MID: begin
        is_pop = 1'b1;
        pos    = (count - 1'b1) >> 1;
      end
      fmbq_pkg::ACT_TAKE_BACK: begin
        is_pop = 1'b1;
        pos    = count - 1'b1;
      end
      default: begin
        // unused codes: no operation
        is_push = 1'b0;
        is_pop  = 1'b0;
      end
    endcase
  end

  assign do_ins = req_acc && is_push && !full;
  assign do_rem = req_acc && is_pop && !empty;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_rem) begin
      count_next = count - 1'b1;
    end
  end

  // Cell chain. Insert: cells past pos take from the front neighbor, cell pos
  // loads the word. Remove: cells from pos on take from the back neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].sel  = (CW'(i) == pos);
      ctl[i].move = fmbq_pkg::MOVE_HOLD;
      if (do_ins) begin
        if (CW'(i) == pos) begin
          ctl[i].move = fmbq_pkg::MOVE_LOAD;
        end else if (CW'(i) > pos) begin
          ctl[i].move = fmbq_pkg::MOVE_LEFT;
        end
      end else if (do_rem) begin
        if (CW'(i) >= pos) begin
          ctl[i].move = fmbq_pkg::MOVE_RIGHT;
        end
      end
    end

    assign sel_vec[i] = ctl[i].sel;

    fmbq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .left_word  ((i == 0) ? words[0] : words[(i == 0) ? 0 : i - 1]),
      .right_word ((i == DEPTH - 1) ? words[DEPTH-1] : words[(i == DEPTH - 1) ? i : i + 1]),
      .new_word   (value),
      .word       (words[i]),
      .read_word  (reads[i])
    );
  end

  // Read-out: at most one cell drives a nonzero word.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | reads[k];
    end
  end

  always_comb begin
    res_word = '0;
    if (is_pop) begin
      res_word = empty ? {DATA_WIDTH{1'b1}} : rd_word;
    end
  end

  // Count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_acc) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      result_value <= res_word;
      empty_error  <= is_pop && empty;
      full_error   <= is_push && full;
      item_count   <= fmbq_pkg::COUNT_OUT_W'(count_next);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count above depth");

  a_one_sel: assert property (@(posedge clk) disable iff (rst)
    $onehot0(sel_vec))
    else $error("more than one cell selected for read");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> res_valid)
    else $error("accepted request gave no result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(empty_error && full_error))
    else $error("empty and full flags both set");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !req_acc |=> count == $past(count))
    else $error("count moved without a request");

endmodule

`default_nettype wire

>>> verif/fmbq_order_checker.sv
// ----------------------------------------------------------------------------
// fmbq_order_checker
// Watches both channels of the front/middle/back queue, keeps its own copy of
// the held words, predicts the result of every accepted request and compares
// it field by field with the result that comes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmbq_order_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic [2:0]                          action,
  input  logic [DATA_WIDTH-1:0]               value,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  logic signed [DATA_WIDTH-1:0]        result_value,
  input  logic                                empty_error,
  input  logic                                full_error,
  input  logic [fmbq_pkg::COUNT_OUT_W-1:0]    item_count,
  output int                                  errors,
  output int                                  pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0]            word;
    logic                             empty_err;
    logic                             full_err;
    logic [fmbq_pkg::COUNT_OUT_W-1:0] count;
  } outcome_t;

  logic [DATA_WIDTH-1:0] held_words[$];  // front of the queue at index 0
  outcome_t              awaited_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Applies one request to the held words and returns what the block must report.
  function automatic outcome_t apply_request(logic [2:0] act, logic [DATA_WIDTH-1:0] word);
    outcome_t o;
    int       n;
    o = '0;
    n = held_words.size();
    case (act)
      fmbq_pkg::ACT_INS_FRONT, fmbq_pkg::ACT_INS_MID, fmbq_pkg::ACT_INS_BACK: begin
        if (n >= DEPTH) o.full_err = 1'b1;
        else if (act == fmbq_pkg::ACT_INS_FRONT) held_words.insert(0, word);
        else if (act == fmbq_pkg::ACT_INS_MID) held_words.insert(n / 2, word);
        else held_words.insert(n, word);
      end
      fmbq_pkg::ACT_TAKE_FRONT, fmbq_pkg::ACT_TAKE_MID, fmbq_pkg::ACT_TAKE_BACK: begin
        if (n == 0) begin
          o.empty_err = 1'b1;
          o.word      = '1;
        end else if (act == fmbq_pkg::ACT_TAKE_FRONT) begin
          o.word = held_words[0];
          held_words.delete(0);
        end else if (act == fmbq_pkg::ACT_TAKE_MID) begin
          o.word = held_words[(n - 1) / 2];
          held_words.delete((n - 1) / 2);
        end else begin
          o.word = held_words[n - 1];
          held_words.delete(n - 1);
        end
      end
      default: ;  // spare codes leave the queue alone
    endcase
    o.count = fmbq_pkg::COUNT_OUT_W'(held_words.size());
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      held_words.delete();
      awaited_results.delete();
    end else begin
      // Result first: the request taken at this same edge is answered later.
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %0d count %0d", $time, result_value,
                   item_count);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (result_value !== want.word) begin
            errors++;
            $display("%0t: result_value expected %0d got %0d", $time, $signed(want.word),
                     result_value);
          end
          if (empty_error !== want.empty_err) begin
            errors++;
            $display("%0t: empty_error expected %0b got %0b", $time, want.empty_err,
                     empty_error);
          end
          if (full_error !== want.full_err) begin
            errors++;
            $display("%0t: full_error expected %0b got %0b", $time, want.full_err,
                     full_error);
          end
          if (item_count !== want.count) begin
            errors++;
            $display("%0t: item_count expected %0d got %0d", $time, want.count, item_count);
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_results.insert(awaited_results.size(), apply_request(action, value));
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> verif/front_middle_back_queue_tb.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_tb
// Drives requests into the front/middle/back queue: a directed pass over the empty
// corner, extreme words and every action, then random phases that
// fill, churn and drain the queue under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module front_middle_back_queue_tb;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int HOLD_CYCLES = 64;    // long result-side hold, fills the block
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;

  // Action codes the block does not define; they must act as no-ops.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             req_valid = 1'b0;
  logic                             req_stall;
  logic [2:0]                       action    = '0;
  logic [DATA_WIDTH-1:0]            value     = '0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0]     result_value;
  logic                             empty_error;
  logic                             full_error;
  logic [fmbq_pkg::COUNT_OUT_W-1:0] item_count;

  int fail_count;
  int awaited;           // results predicted but not yet seen
  int req_idle_pct = 20;
  int res_idle_pct = 20;
  int holds_asked  = 0;  // bumped by stimulus, served by the receiver
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  front_middle_back_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .value        (value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_value (result_value),
    .empty_error  (empty_error),
    .full_error   (full_error),
    .item_count   (item_count)
  );

  fmbq_order_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .value        (value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_value (result_value),
    .empty_error  (empty_error),
    .full_error   (full_error),
    .item_count   (item_count),
    .errors       (fail_count),
    .pending      (awaited)
  );

  // Receiver: random stall, plus one long hold whenever stimulus asks for it.
  // The hold is counted here so the sender keeps pushing requests meanwhile.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        repeat (HOLD_CYCLES) begin
          res_stall <= 1'b1;
          @(posedge clk);
        end
      end
      res_stall <= ($urandom_range(99) < res_idle_pct);
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one request, with a random idle gap in front, and hold it until taken.
  task automatic send_req(input logic [2:0] act, input logic [DATA_WIDTH-1:0] word);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    value     <= word;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Spare codes now and then; otherwise a push with the given odds, else a pop.
  function automatic logic [2:0] pick_action(int push_pct);
    logic [2:0] a;
    if ($urandom_range(99) < 4) begin
      a = $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
    end else if ($urandom_range(99) < push_pct) begin
      case ($urandom_range(2))
        0:       a = fmbq_pkg::ACT_INS_FRONT;
        1:       a = fmbq_pkg::ACT_INS_MID;
        default: a = fmbq_pkg::ACT_INS_BACK;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       a = fmbq_pkg::ACT_TAKE_FRONT;
        1:       a = fmbq_pkg::ACT_TAKE_MID;
        default: a = fmbq_pkg::ACT_TAKE_BACK;
      endcase
    end
    return a;
  endfunction

  // Words lean toward the signed extremes, zero and all ones.
  function automatic logic [DATA_WIDTH-1:0] pick_word();
    logic [DATA_WIDTH-1:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h7FFF_FFFF;
      3:       w = 32'h8000_0000;
      4:       w = $urandom_range(15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  initial begin : stimulus
    int push_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // pops on an empty queue: -1 with the empty flag, value ignored
    send_req(fmbq_pkg::ACT_TAKE_FRONT, '1);
    send_req(fmbq_pkg::ACT_TAKE_MID, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_BACK, 32'h8000_0000);
    // spare codes on an empty queue
    send_req(ACT_SPARE_6, '1);
    send_req(ACT_SPARE_7, 32'h5A5A_5A5A);
    // extremes at every insert point
    send_req(fmbq_pkg::ACT_INS_BACK, 32'h7FFF_FFFF);
    send_req(fmbq_pkg::ACT_INS_FRONT, 32'h8000_0000);
    send_req(fmbq_pkg::ACT_INS_MID, 32'h0);
    send_req(fmbq_pkg::ACT_INS_MID, '1);
    send_req(fmbq_pkg::ACT_INS_BACK, 32'h1);
    send_req(fmbq_pkg::ACT_INS_FRONT, 32'h5555_5555);
    send_req(fmbq_pkg::ACT_INS_MID, 32'hAAAA_AAAA);
    send_req(ACT_SPARE_7, 32'h0);
    // middle pop on odd and then even counts
    send_req(fmbq_pkg::ACT_TAKE_MID, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_MID, '1);
    send_req(fmbq_pkg::ACT_TAKE_FRONT, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_BACK, 32'h0);
    send_req(fmbq_pkg::ACT_INS_MID, 32'h1234_5678);
    send_req(fmbq_pkg::ACT_TAKE_MID, 32'h0);
    // drain past empty
    send_req(fmbq_pkg::ACT_TAKE_BACK, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_FRONT, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_MID, 32'h0);
    send_req(fmbq_pkg::ACT_TAKE_BACK, 32'h0);

    // --- random phases: fill (full pushes dropped), churn, drain ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       push_pct = 80;
        1:       push_pct = 50;
        default: push_pct = 20;
      endcase
      // one phase runs back to back with no idling on either side
      req_idle_pct = (ph == 4) ? 0 : 20;
      res_idle_pct = (ph == 4) ? 0 : 20;
      if (ph == 2) holds_asked++;  // long receiver hold while requests keep coming
      if (ph == 7) begin
        // sender goes quiet until every result is back
        req_valid <= 1'b0;
        @(posedge clk);
        wait (awaited == 0);
      end
      repeat (PHASE_ITEMS) send_req(pick_action(push_pct), pick_word());
    end

    req_valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (4) @(posedge clk);  // room for any stray result after the last one
    if (fail_count == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> front_middle_back_queue.f
hw/rtl/fmbq_pkg.sv
hw/rtl/fmbq_cell.sv
hw/rtl/front_middle_back_queue.sv
verif/fmbq_order_checker.sv
verif/front_middle_back_queue_tb.sv
